// ===== design/invc_pkg.sv =====
// Shared constants and types of the inversion counter.
`default_nettype none

package invc_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int VALUE_W      = 32;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int CNT_W        = $clog2(MAX_ELEMENTS);
    localparam int TOTAL_W      = 20;
    localparam int OUT_W        = 19;

    localparam logic [IDX_W-1:0] IDX_FULL  = IDX_W'(MAX_ELEMENTS);
    localparam logic [OUT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               ovf;
        logic [IDX_W-1:0]   idx;
        logic [CNT_W-1:0]   cnt;
    } t_token;

endpackage

`default_nettype wire

// ===== design/invc_if.sv =====
// Request channel interfaces of the inversion counter.
`default_nettype none

interface invc_in_if;
    import invc_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               last;

    modport source (output valid, output value, output last, input ready);
    modport sink (input valid, input value, input last, output ready);
endinterface

interface invc_out_if;
    import invc_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] inversion_count;
    logic             overflow;

    modport source (output valid, output inversion_count, output overflow, input ready);
    modport sink (input valid, input inversion_count, input overflow, output ready);
endinterface

`default_nettype wire

// ===== design/invc_cell.sv =====
// One cell of the comparison chain: holds one stored element and counts a passing request.
`default_nettype none

module invc_cell (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_adv,
    input  wire logic [invc_pkg::IDX_W-1:0] i_cell_idx,
    input  wire invc_pkg::t_token          i_tok,
    output invc_pkg::t_token               o_tok
);
    import invc_pkg::*;

    t_token             r_tok;
    t_token             n_tok;
    logic [VALUE_W-1:0] r_store;
    logic [VALUE_W-1:0] n_store;

    always_comb begin
        n_tok   = i_tok;
        n_store = r_store;
        if (i_tok.valid && !i_tok.ovf) begin
            if (i_cell_idx == i_tok.idx) begin
                n_store = i_tok.value;
            end else if ((i_cell_idx < i_tok.idx)
                         && ($signed(r_store) > $signed(i_tok.value))) begin
                n_tok.cnt = i_tok.cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_store <= n_store;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

// ===== design/invc_accum.sv =====
// Tail of the chain: running total, overflow flag and the result register.
`default_nettype none

module invc_accum (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire invc_pkg::t_token i_tok,
    output logic                  o_adv,
    invc_out_if.source            o_out
);
    import invc_pkg::*;

    logic [TOTAL_W-1:0] r_total;
    logic [TOTAL_W-1:0] n_total;
    logic [TOTAL_W:0]   w_sum;
    logic               r_ovf;
    logic               n_ovf;
    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_count;
    logic [OUT_W-1:0]   n_out_count;
    logic               r_out_ovf;

    assign o_adv = !r_out_valid || o_out.ready;
    assign w_sum = {1'b0, r_total} + (TOTAL_W + 1)'(i_tok.cnt);

    always_comb begin
        if (w_sum[TOTAL_W]) begin
            n_total = '1;
        end else begin
            n_total = w_sum[TOTAL_W-1:0];
        end
        n_ovf = r_ovf || i_tok.ovf;
        if (|n_total[TOTAL_W-1:OUT_W]) begin
            n_out_count = COUNT_MAX;
        end else begin
            n_out_count = n_total[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (o_adv) begin
            r_out_valid <= i_tok.valid && i_tok.last;
            if (i_tok.valid) begin
                if (i_tok.last) begin
                    r_total <= '0;
                    r_ovf   <= 1'b0;
                end else begin
                    r_total <= n_total;
                    r_ovf   <= n_ovf;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_tok.valid && i_tok.last) begin
            r_out_count <= n_out_count;
            r_out_ovf   <= n_ovf;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.inversion_count = r_out_count;
    assign o_out.overflow        = r_out_ovf;

endmodule

`default_nettype wire

// ===== design/inversion_counter.sv =====
// Top level of the inversion counter: element counter, cell chain and accumulator.
//
// Elements of one array arrive as requests on i_in (value, last); the
// element flagged last ends the array. One result request leaves on o_out
// per array, carrying the inversion count and the overflow flag.
// Every element travels the whole chain of MAX_ELEMENTS cells, one cell
// per cycle while the chain advances; the cell whose position matches the
// element's index stores it, and every lower cell adds one if its stored
// element is greater. One element is accepted per cycle while the chain
// advances. The result is registered once the last element has passed
// every cell. Elements past capacity are not stored and set overflow.
// When o_out is stalled with a result waiting, the whole chain holds and
// i_in.ready falls; nothing is lost. Reset clears the element counter,
// the running total and every valid bit in the chain; stored elements need
// no clearing, since a cell is only compared once the current array has
// written it. No clearing pass is needed after reset.
`default_nettype none

module inversion_counter (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    invc_in_if.sink    i_in,
    invc_out_if.source o_out
);
    import invc_pkg::*;

    logic             w_adv;
    logic [IDX_W-1:0] r_count;
    t_token           w_tok [MAX_ELEMENTS+1];

    assign i_in.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_in.valid && w_adv) begin
            if (i_in.last) begin
                r_count <= '0;
            end else if (r_count != IDX_FULL) begin
                r_count <= r_count + IDX_W'(1);
            end
        end
    end

    always_comb begin
        w_tok[0].valid = i_in.valid;
        w_tok[0].value = i_in.value;
        w_tok[0].last  = i_in.last;
        w_tok[0].ovf   = (r_count == IDX_FULL);
        w_tok[0].idx   = r_count;
        w_tok[0].cnt   = '0;
    end

    for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
        invc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_adv      (w_adv),
            .i_cell_idx (IDX_W'(g)),
            .i_tok      (w_tok[g]),
            .o_tok      (w_tok[g+1])
        );
    end

    invc_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (w_tok[MAX_ELEMENTS]),
        .o_adv   (w_adv),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb_inversion_counter.sv =====
// Self-checking testbench of the inversion counter: streamed arrays, tallied and checked per result.
`default_nettype none

module tb_inversion_counter;
    import invc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned HOLD_CYCLES = 2500;
    localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    class inversion_tally;
        typedef struct packed {
            logic [OUT_W-1:0] count;
            logic             ovf;
        } t_tally;

        logic signed [VALUE_W-1:0] held_values[$];
        int unsigned running;
        bit          dropped;
        t_tally      awaited[$];
        int unsigned errors;
        int unsigned checked;
        int unsigned arrays;
        int unsigned overflowed;
        int unsigned longest;
        int unsigned current_len;

        task report(input string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $time, msg);
        endtask

        function void note_element(input logic signed [VALUE_W-1:0] v, input logic lst);
            t_tally      exp_t;
            int unsigned greater;
            current_len++;
            if (held_values.size() < MAX_ELEMENTS) begin
                greater = 0;
                foreach (held_values[i])
                    if (held_values[i] > v)
                        greater++;
                running += greater;
                held_values = {held_values, v};
            end else begin
                dropped = 1'b1;
            end
            if (lst) begin
                exp_t.count = (running > COUNT_MAX) ? COUNT_MAX : running[OUT_W-1:0];
                exp_t.ovf   = dropped;
                awaited = {awaited, exp_t};
                arrays++;
                if (dropped)
                    overflowed++;
                if (current_len > longest)
                    longest = current_len;
                current_len = 0;
                held_values.delete();
                running = 0;
                dropped = 1'b0;
            end
        endfunction

        task check_result(input logic [OUT_W-1:0] cnt, input logic ovf);
            t_tally exp_t;
            checked++;
            if (awaited.size() == 0) begin
                report($sformatf("unexpected result count=%0d overflow=%0b", cnt, ovf));
            end else begin
                exp_t = awaited.pop_front();
                if (cnt !== exp_t.count)
                    report($sformatf("inversion_count %0d, expected %0d", cnt, exp_t.count));
                if (ovf !== exp_t.ovf)
                    report($sformatf("overflow %0b, expected %0b", ovf, exp_t.ovf));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   quiet;
    int unsigned cycle_count;
    int unsigned elements_sent;

    inversion_tally sb = new();

    invc_in_if  in_ch();
    invc_out_if out_ch();

    inversion_counter dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        int                 s;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom();
            4:          v = $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
            default: begin
                s = int'($urandom_range(0, 8)) - 4;
                v = s;
            end
        endcase
        return v;
    endfunction

    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 8);
        else if (r < 95)
            return $urandom_range(9, 40);
        else
            return $urandom_range(41, 150);
    endfunction

    task automatic send_element(input logic [VALUE_W-1:0] v, input logic lst);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        in_ch.last  <= lst;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_element(v, lst);
        elements_sent++;
    endtask

    task automatic send_random_array();
        int unsigned len;
        len = pick_len();
        quiet = ($urandom_range(0, 7) == 0);
        for (int unsigned i = 0; i < len; i++)
            send_element(pick_value(), i == len - 1);
    endtask

    task automatic send_overfull_array();
        logic [VALUE_W-1:0] base;
        int unsigned        len;
        base = $urandom_range(0, 32'h3FFF_FFFF);
        len  = MAX_ELEMENTS + $urandom_range(1, 6);
        quiet = 1'b0;
        for (int unsigned i = 0; i < len; i++)
            send_element((i < MAX_ELEMENTS) ? base - i : pick_value(), i == len - 1);
    endtask

    initial begin : result_sink
        bit          held;
        int unsigned stall;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (!held && sb.checked == 5) begin
                held  = 1'b1;
                stall = HOLD_CYCLES;
            end else begin
                stall = pick_gap();
            end
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            sb.check_result(out_ch.inversion_count, out_ch.overflow);
        end
    end

    initial begin : element_source
        int unsigned random_start;
        rst_n       <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.value <= '0;
        in_ch.last  <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        send_element('0, 1'b1);
        send_element(VALUE_MAX, 1'b0);
        send_element(VALUE_MIN, 1'b1);
        send_element(VALUE_MIN, 1'b0);
        send_element(VALUE_MAX, 1'b1);
        send_element('1, 1'b0);
        send_element('0, 1'b0);
        send_element('1, 1'b0);
        send_element(32'd5, 1'b0);
        send_element(32'd5, 1'b1);
        send_element(32'd3, 1'b0);
        send_element(32'd3, 1'b0);
        send_element(32'd3, 1'b1);
        send_element(VALUE_MAX, 1'b0);
        send_element('0, 1'b0);
        send_element('1, 1'b0);
        send_element(VALUE_MIN, 1'b1);
        send_element(VALUE_MIN, 1'b1);

        random_start = elements_sent;
        while (elements_sent - random_start < 500)
            send_random_array();
        send_overfull_array();
        while (elements_sent - random_start < 1950 || sb.arrays < 60)
            send_random_array();
        in_ch.valid <= 1'b0;
        quiet = 1'b0;

        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (MAX_ELEMENTS + 16) @(posedge clk);

        $display("Streamed %0d arrays of %0d elements in total, longest %0d, %0d past capacity.",
                 sb.arrays, elements_sent, sb.longest, sb.overflowed);
        $display("Checked %0d results with %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
design/invc_pkg.sv
design/invc_if.sv
design/invc_cell.sv
design/invc_accum.sv
design/inversion_counter.sv
tb/sv/tb_inversion_counter.sv
